### rtl/core/compass_heading_atan2_macros.svh
// Assertion helpers for the compass heading core.
`ifndef COMPASS_HEADING_ATAN2_MACROS_SVH
`define COMPASS_HEADING_ATAN2_MACROS_SVH

// Checked on every rising clk_i edge once reset is released.
`define CHDG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define CHDG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/chdg_pkg.sv
package chdg_pkg;

  localparam int RAW_W     = 16;  // sample and register width
  localparam int DIFF_W    = 17;  // offset-corrected sample
  localparam int PRE_SHIFT = 8;   // CORDIC input scale
  localparam int XY_W      = 27;  // CORDIC datapath, covers gain and scale
  localparam int PHASE_W   = 32;  // angle as binary fraction of a turn
  localparam int ATAN_LEN  = 24;
  localparam int HEAD_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HARD_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HARD_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 2'd2;

  localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [PHASE_W-1:0]     phase;
    logic                   zero;
  } cordic_t;

  // atan(2^-i) as a fraction of a full turn
  function automatic logic [PHASE_W-1:0] atan_turn(input int idx);
    logic [PHASE_W-1:0] a;
    case (idx)
      0:  a = 32'h2000_0000;
      1:  a = 32'h12E4_051E;
      2:  a = 32'h09FB_385B;
      3:  a = 32'h0511_11D4;
      4:  a = 32'h028B_0D43;
      5:  a = 32'h0145_D7E1;
      6:  a = 32'h00A2_F61E;
      7:  a = 32'h0051_7C55;
      8:  a = 32'h0028_BE53;
      9:  a = 32'h0014_5F2F;
      10: a = 32'h000A_2F98;
      11: a = 32'h0005_17CC;
      12: a = 32'h0002_8BE6;
      13: a = 32'h0001_45F3;
      14: a = 32'h0000_A2FA;
      15: a = 32'h0000_517D;
      16: a = 32'h0000_28BE;
      17: a = 32'h0000_145F;
      18: a = 32'h0000_0A2F;
      19: a = 32'h0000_0517;
      20: a = 32'h0000_028B;
      21: a = 32'h0000_0145;
      22: a = 32'h0000_00A2;
      23: a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/chdg_if.sv
interface chdg_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [chdg_pkg::RAW_W-1:0]   raw_x;
  logic signed [chdg_pkg::RAW_W-1:0]   raw_y;
  modport source (output valid, raw_x, raw_y, input ready);
  modport sink   (input valid, raw_x, raw_y, output ready);
endinterface

interface chdg_heading_if;
  logic                                valid;
  logic                                ready;
  logic [chdg_pkg::HEAD_W-1:0]         heading;
  modport source (output valid, heading, input ready);
  modport sink   (input valid, heading, output ready);
endinterface

interface chdg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [chdg_pkg::CFG_IDX_W-1:0]      index;
  logic [chdg_pkg::RAW_W-1:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/chdg_cordic_stage.sv
// One registered vectoring CORDIC micro-rotation.
module chdg_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  chdg_pkg::cordic_t data_i,
  output chdg_pkg::cordic_t data_o
);
  import chdg_pkg::*;

  logic signed [XY_W-1:0] xs, ys;
  cordic_t                data_d, data_q;

  always_comb begin
    xs     = data_i.x >>> STAGE;  // floor shift
    ys     = data_i.y >>> STAGE;
    data_d = data_i;
    if (!data_i.y[XY_W-1]) begin
      data_d.x     = data_i.x + ys;
      data_d.y     = data_i.y - xs;
      data_d.phase = data_i.phase + atan_turn(STAGE);
    end else begin
      data_d.x     = data_i.x - ys;
      data_d.y     = data_i.y + xs;
      data_d.phase = data_i.phase - atan_turn(STAGE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### rtl/core/compass_heading_atan2.sv
// Compass heading: atan2 of offset-corrected field, plus declination, in [0, 360).
//
//  channel    role   modport   transaction payload
//  --------   ----   -------   --------------------------------------------
//  sample_i   in     sink      raw_x, raw_y (16b signed)
//  heading_o  out    source    heading (16b, 2^-ANGLE_FRAC_BITS degree)
//  cfg_i      in     sink      index (0 hard-iron X, 1 hard-iron Y, 2 declination),
//                              data (16b); other index ignored, always ready
//
// One sample pair per cycle sustained while heading_o is ready; the pipe has
// one register stage per CORDIC micro-rotation plus five fixed stages.
// Each stage keeps its own valid bit and loads when it is empty or the
// stage after it moves, so bubbles close up and a stalled output still lets
// new samples in until the pipe is full. No transaction is dropped or repeated.
// rst_ni (async, low) clears the valid bits and the config registers (all 0).
module compass_heading_atan2 #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  chdg_sample_if.sink           sample_i,
  chdg_heading_if.source        heading_o,
  chdg_cfg_if.sink              cfg_i
);
  import chdg_pkg::*;

  `include "compass_heading_atan2_macros.svh"

  // Pipeline stage map
  localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int S_DXY = 0;           // offset subtraction
  localparam int S_PRE = 1;           // half-plane fold and scaling
  localparam int S_MUL = STEPS + 2;   // turn fraction times full circle
  localparam int S_RND = STEPS + 3;   // round, add declination
  localparam int S_WRP = STEPS + 4;   // wrap into one circle, output register
  localparam int NS    = STEPS + 5;

  // Angle output arithmetic
  localparam int FULL   = 360 << ANGLE_FRAC_BITS;
  localparam int FW     = $clog2(FULL + 1);
  localparam int PW     = PHASE_W + FW;
  localparam int DMAG   = 2 ** (RAW_W - 1);           // largest |declination|
  localparam int NWRAP  = (DMAG + FULL - 1) / FULL;   // turns added to stay >= 0
  localparam int VMAX   = FULL - 1 + DMAG - 1 + NWRAP * FULL;
  localparam int VW     = $clog2(VMAX + 1);
  localparam int WSTEPS = $clog2((VMAX + FULL) / FULL);

  logic [NS-1:0] valid_q;
  logic [NS-1:0] en;

  // Configuration registers
  logic signed [RAW_W-1:0] x_off_q, y_off_q, decl_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q <= '0;
      y_off_q <= '0;
      decl_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_HARD_X:      x_off_q <= cfg_i.data;
        REG_HARD_Y:      y_off_q <= cfg_i.data;
        REG_DECLINATION: decl_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Flow control: a stage loads when empty or when its successor moves
  always_comb begin
    en[NS-1] = !valid_q[NS-1] || heading_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign sample_i.ready = en[S_DXY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? sample_i.valid : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Stage 0: hard-iron correction
  logic signed [DIFF_W-1:0] dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (en[S_DXY]) begin
      dx_q <= DIFF_W'(sample_i.raw_x) - DIFF_W'(x_off_q);
      dy_q <= DIFF_W'(sample_i.raw_y) - DIFF_W'(y_off_q);
    end
  end

  // Stage 1: fold the left half plane by 180 degrees, scale up
  cordic_t                cd [0:STEPS];
  cordic_t                pre_d, pre_q;
  logic signed [XY_W-1:0] xe, ye;

  always_comb begin
    xe          = XY_W'(dx_q);
    ye          = XY_W'(dy_q);
    pre_d.zero  = (dx_q == '0) && (dy_q == '0);
    pre_d.phase = '0;
    if (dx_q[DIFF_W-1]) begin
      xe          = -xe;
      ye          = -ye;
      pre_d.phase = HALF_TURN;
    end
    pre_d.x = xe <<< PRE_SHIFT;
    pre_d.y = ye <<< PRE_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (en[S_PRE]) begin
      pre_q <= pre_d;
    end
  end

  assign cd[0] = pre_q;

  // CORDIC micro-rotations, one register stage each
  for (genvar j = 0; j < STEPS; j++) begin : g_cordic
    chdg_cordic_stage #(
      .STAGE (j)
    ) u_stage (
      .clk_i  (clk_i),
      .en_i   (en[S_PRE + 1 + j]),
      .data_i (cd[j]),
      .data_o (cd[j+1])
    );
  end

  // Turn fraction to angle units: phase * FULL, a zero vector gives 0
  logic [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en[S_MUL]) begin
      prod_q <= cd[STEPS].zero ? '0 : PW'(cd[STEPS].phase) * PW'(FULL);
    end
  end

  // Round half up, fold a full circle to 0, add declination biased positive
  logic [PW:0]     rnd_sum;
  logic [FW:0]     hr;
  logic [FW:0]     hfix;
  logic [VW:0]     vsum;
  logic [VW-1:0]   rnd_q;

  always_comb begin
    rnd_sum = (PW + 1)'(prod_q) + ((PW + 1)'(1) << (PHASE_W - 1));
    hr      = rnd_sum[PW:PHASE_W];
    hfix    = (hr == (FW + 1)'(FULL)) ? '0 : hr;
    vsum    = (VW + 1)'(hfix) + (VW + 1)'(decl_q) + (VW + 1)'(NWRAP * FULL);
  end

  always_ff @(posedge clk_i) begin
    if (en[S_RND]) begin
      rnd_q <= vsum[VW-1:0];
    end
  end

  // Wrap: binary conditional subtraction of FULL * 2^k
  logic [VW:0]   wv;
  logic [FW-1:0] hd_q;

  always_comb begin
    wv = (VW + 1)'(rnd_q);
    for (int k = WSTEPS - 1; k >= 0; k--) begin
      if (wv >= ((VW + 1)'(FULL) << k)) begin
        wv = wv - ((VW + 1)'(FULL) << k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_WRP]) begin
      hd_q <= FW'(wv);
    end
  end

  assign heading_o.valid   = valid_q[S_WRP];
  assign heading_o.heading = HEAD_W'(hd_q);

  // Checks
  logic acc_in, acc_out;
  assign acc_in  = sample_i.valid && sample_i.ready;
  assign acc_out = heading_o.valid && heading_o.ready;

  `CHDG_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> (valid_q == '0), "pipe not empty in reset")
  `CHDG_ASSERT(a_head_range, valid_q[S_WRP] |-> (hd_q < FW'(FULL)), "heading beyond circle")
  `CHDG_ASSERT(a_rnd_range, valid_q[S_RND] |-> (rnd_q <= VW'(VMAX)), "biased sum out of range")
  `CHDG_ASSERT(a_room_accept, !valid_q[S_WRP] |-> sample_i.ready, "input stalled with room")
  `CHDG_ASSERT(a_conserve, $countones(valid_q) == $past($countones(valid_q)) + $past(acc_in) - $past(acc_out), "items lost or duplicated")

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import chdg_pkg::*;

  // Same values as the block's defaults; passed down explicitly.
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int PIPE_LATENCY    = CORDIC_STEPS + 5;
  localparam int CLK_HALF        = 5;

  // Index with no register behind it; the block must drop writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // atan(2^-i) as a binary fraction of one turn.
  localparam logic [PHASE_W-1:0] ARCTAN_TURNS [ATAN_LEN] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
  };

  typedef struct {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic [HEAD_W-1:0]       heading;
  } heading_pred_t;

  logic clk_i;
  logic rst_ni;

  chdg_sample_if  sample_if ();
  chdg_heading_if heading_if ();
  chdg_cfg_if     cfg_if ();

  compass_heading_atan2 #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_if),
    .heading_o (heading_if),
    .cfg_i     (cfg_if)
  );

  // Shadow copy of the config registers, updated on each accepted write.
  logic signed [RAW_W-1:0] hard_x_q;
  logic signed [RAW_W-1:0] hard_y_q;
  logic signed [RAW_W-1:0] declination_q;

  heading_pred_t pending_headings [$];
  heading_pred_t oldest;

  int  n_samples;
  int  n_headings;
  int  n_cfg_writes;
  int  n_settings;
  int  n_errors;
  int  burst_left;
  bit  back_to_back;   // sender skips its idle gaps while set
  int  hold_off_cycles; // nonzero: receiver drops ready for that long

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog: even the slowest legal run finishes far earlier.
  initial begin
    #2_000_000;
    $display("watchdog expired: %0d transactions still outstanding",
             pending_headings.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: offset correction, vectoring CORDIC on a 32-bit turn fraction,
  // conversion to 2^-ANGLE_FRAC_BITS degree with round half up, then
  // declination and wrap into one full circle.
  // ---------------------------------------------------------------------------
  function automatic logic [HEAD_W-1:0] heading_of(input logic signed [RAW_W-1:0] rx,
                                                   input logic signed [RAW_W-1:0] ry);
    longint             vx, vy, sx, sy, full, h;
    logic [PHASE_W-1:0] phase;
    logic [63:0]        prod;
    int                 steps;
    vx    = longint'(rx) - longint'(hard_x_q);
    vy    = longint'(ry) - longint'(hard_y_q);
    phase = '0;
    if (vx != 0 || vy != 0) begin
      // left half plane: fold over by half a turn so CORDIC converges
      if (vx < 0) begin
        vx    = -vx;
        vy    = -vy;
        phase = HALF_TURN;
      end
      vx    = vx * (longint'(1) << PRE_SHIFT);
      vy    = vy * (longint'(1) << PRE_SHIFT);
      steps = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
      for (int i = 0; i < steps; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy >= 0) begin
          vx    = vx + sy;
          vy    = vy - sx;
          phase = phase + ARCTAN_TURNS[i];
        end else begin
          vx    = vx - sy;
          vy    = vy + sx;
          phase = phase - ARCTAN_TURNS[i];
        end
      end
    end
    full = longint'(360) << ANGLE_FRAC_BITS;
    prod = 64'(phase) * 64'(full) + 64'h8000_0000;
    h    = longint'(prod >> 32);
    if (h >= full) h = h - full;
    h = (h + longint'(declination_q)) % full;
    if (h < 0) h = h + full;
    return 16'(h);
  endfunction

  // ---------------------------------------------------------------------------
  // Heading checker: every output transaction against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && heading_if.valid === 1'b1 && heading_if.ready === 1'b1) begin
      if (pending_headings.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: unexpected heading transaction, heading=%0d",
                   $realtime, heading_if.heading);
      end else begin
        oldest = pending_headings.pop_front();
        n_headings++;
        if (heading_if.heading !== oldest.heading) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: heading mismatch for x=%0d y=%0d: expected %0d, got %0d",
                     $realtime, oldest.raw_x, oldest.raw_y, oldest.heading,
                     heading_if.heading);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output receiver: switches between stall patterns at random intervals.
  // A test may ask for one long hold-off through hold_off_cycles.
  // ---------------------------------------------------------------------------
  initial begin : heading_sink
    int mode;
    int span;
    int hold;
    heading_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 256);
      repeat (span) begin
        if (hold_off_cycles > 0) begin
          hold            = hold_off_cycles;
          hold_off_cycles = 0;
          heading_if.ready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
        case (mode)
          0:       heading_if.ready <= 1'b1;                          // always taking
          1:       heading_if.ready <= 1'($urandom_range(0, 1));      // coin flip
          2:       heading_if.ready <= ($urandom_range(0, 7) != 0);   // rare stalls
          default: heading_if.ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
        endcase
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample sender and helpers
  // ---------------------------------------------------------------------------

  // One sample transaction; the prediction is queued at the accepting edge.
  // valid stays high on return, unless an idle gap follows, so the next call can follow back to back.
  task automatic send_sample(input logic signed [RAW_W-1:0] rx,
                             input logic signed [RAW_W-1:0] ry);
    heading_pred_t p;
    sample_if.valid <= 1'b1;
    sample_if.raw_x <= rx;
    sample_if.raw_y <= ry;
    @(posedge clk_i);
    while (sample_if.ready !== 1'b1) @(posedge clk_i);
    p.raw_x   = rx;
    p.raw_y   = ry;
    p.heading = heading_of(rx, ry);
    pending_headings.push_back(p);
    n_samples++;
    // bursts of random length, then a random idle gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      if (!back_to_back) begin
        sample_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering samples, let every heading come out and the pipe go quiet.
  task automatic drain_pipe();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_headings.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // cfg_i reports always ready, but the handshake is honored anyway.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [RAW_W-1:0] value, input bit last);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    case (idx)
      REG_HARD_X:      hard_x_q      = value;
      REG_HARD_Y:      hard_y_q      = value;
      REG_DECLINATION: declination_q = value;
      default: ;
    endcase
    n_cfg_writes++;
    if (last) cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [RAW_W-1:0] xo, input logic [RAW_W-1:0] yo,
                            input logic [RAW_W-1:0] decl);
    write_reg(REG_HARD_X, xo, 1'b0);
    write_reg(REG_HARD_Y, yo, 1'b0);
    write_reg(REG_DECLINATION, decl, 1'b1);
    n_settings++;
  endtask

  // Random sample field: mostly full range, plus values that land on or near
  // the offset (axes, zero vector, tiny vectors), the 16-bit extremes and small raw values.
  function automatic logic signed [RAW_W-1:0] pick_raw(input logic signed [RAW_W-1:0] off);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return RAW_W'($urandom);
    if (sel < 70) return off + RAW_W'($urandom_range(0, 16)) - RAW_W'(8);
    if (sel < 80) return off;
    if (sel < 90) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return RAW_W'($urandom_range(0, 512)) - RAW_W'(256);
  endfunction

  function automatic logic [RAW_W-1:0] pick_offset();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_declination();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;               // most negative, beyond -180 deg
      1:       return 16'h7FFF;
      2:       return RAW_W'(23040);          // +180 deg
      3:       return RAW_W'(-23040);         // -180 deg
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values (all zero): cardinal directions, zero vector, left half
  // plane and the sample extremes.
  task automatic test_reset_headings();
    send_sample(16'sd0, 16'sd0);          // zero vector
    send_sample(16'sd100, 16'sd0);        // 0 deg
    send_sample(16'sd0, 16'sd100);        // 90 deg
    send_sample(-16'sd100, 16'sd0);       // exactly 180, folded
    send_sample(16'sd0, -16'sd100);       // 270 deg
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sd0);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(-16'sd1, 16'sd1);
    drain_pipe();
  endtask

  // Offsets at their extremes push the corrected vector to the 17-bit limits.
  task automatic test_offset_extremes();
    set_config(16'h8000, 16'h7FFF, 16'h0000);
    send_sample(16'sh7FFF, 16'sh8000);    // dx = +65535, dy = -65535
    send_sample(16'sh8000, 16'sh7FFF);    // zero vector through the offsets
    send_sample(16'sd0, 16'sd0);
    drain_pipe();
    set_config(16'h7FFF, 16'h8000, 16'h0000);
    send_sample(16'sh8000, 16'sh7FFF);    // dx = -65535, dy = +65535
    send_sample(16'sh7FFF, 16'sh8000);    // zero vector again
    drain_pipe();
  endtask

  // Declination extremes, wrap in both directions, and a write to the
  // unmapped index that must leave the registers alone.
  task automatic test_declination_wrap();
    set_config(16'h0000, 16'h0000, 16'h7FFF);
    send_sample(16'sd1, 16'sd0);
    send_sample(-16'sd1, 16'sd0);         // 180 deg + declination wraps
    drain_pipe();
    set_config(16'h0000, 16'h0000, 16'h8000);
    send_sample(16'sd1, 16'sd0);          // negative sum wraps up
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd0, 16'sd0);          // zero vector still gets declination
    drain_pipe();
    set_config(16'h0000, 16'h0000, RAW_W'(-23040));
    @(posedge clk_i);
    write_reg(REG_UNMAPPED, 16'h1234, 1'b1);
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd5, 16'sd5);
    drain_pipe();
  endtask

  // Random samples over several random register settings.
  task automatic test_random_samples(input int phases, input int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      set_config(pick_offset(), pick_offset(), pick_declination());
      back_to_back = (ph % 3 == 2);   // some phases with no sender gaps at all
      repeat (per_phase) send_sample(pick_raw(hard_x_q), pick_raw(hard_y_q));
      back_to_back = 1'b0;
      drain_pipe();
    end
  endtask

  // Receiver stops for a long stretch while samples keep coming, so the
  // pipe fills up and sample_i.ready has to drop.
  task automatic test_stalled_output();
    set_config(pick_offset(), pick_offset(), pick_declination());
    hold_off_cycles = 300;
    back_to_back    = 1'b1;
    repeat (64) send_sample(pick_raw(hard_x_q), pick_raw(hard_y_q));
    back_to_back    = 1'b0;
    drain_pipe();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          <= 1'b0;
    sample_if.valid <= 1'b0;
    sample_if.raw_x <= '0;
    sample_if.raw_y <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_HARD_X;
    cfg_if.data     <= '0;
    hard_x_q        = '0;
    hard_y_q        = '0;
    declination_q   = '0;
    n_samples       = 0;
    n_headings      = 0;
    n_cfg_writes    = 0;
    n_settings      = 1;
    n_errors        = 0;
    burst_left      = 0;
    back_to_back    = 1'b0;
    hold_off_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_headings();
    test_offset_extremes();
    test_declination_wrap();
    test_random_samples(6, 140);
    test_stalled_output();

    $display("Summary: %0d samples in, %0d headings checked, %0d register writes over %0d settings",
             n_samples, n_headings, n_cfg_writes, n_settings);
    $display("  (offset/declination extremes, zero vectors, left half plane, 300-cycle output stall)");
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors", n_errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/chdg_pkg.sv
rtl/core/chdg_if.sv
rtl/core/chdg_cordic_stage.sv
rtl/core/compass_heading_atan2.sv
tb/tb.sv
